// File: hw/rtl/aar_pkg.sv
// shared types, constants and helper functions for the axis-angle rotation matrix
package aar_pkg;

    localparam int ANGLE_W = 24;
    localparam int AXIS_W  = 18;
    localparam int Z_W     = 32;
    localparam int C_W     = 19;
    localparam int OMC_W   = 20;
    localparam int PP_W    = 2 * AXIS_W;
    localparam int NS_W    = AXIS_W + C_W;
    localparam int Q_W     = PP_W + OMC_W;
    localparam int SUM_W   = 58;
    localparam int OUT_W   = 19;
    localparam int NUM_OUT = 9;
    localparam int MAX_STEPS = 30;

    localparam logic [29:0] PHASE_PER_RAD = 30'd683565276;
    localparam logic [63:0] GAIN_INV_Q32  = 64'd2608131496;
    localparam logic signed [OMC_W-1:0] ONE_Q16 = 20'sd65536;
    localparam logic signed [25:0] OUT_MAX = 26'sd262143;
    localparam logic signed [25:0] OUT_MIN = -26'sd262144;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axis;

    typedef struct packed {
        logic valid;
        logic flip;
    } t_cell_ctl;

    // arctangent of 2^-i in phase units, one full turn = 2^32
    function automatic logic [Z_W-1:0] atan_phase(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round q.48 to q.16, halves up, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        logic signed [25:0] t;
        logic signed [OUT_W-1:0] o;
        r = v + $signed(SUM_W'(64'd1 << 31));
        t = r[SUM_W-1:32];
        if (t > OUT_MAX) begin
            o = OUT_MAX[OUT_W-1:0];
        end else if (t < OUT_MIN) begin
            o = OUT_MIN[OUT_W-1:0];
        end else begin
            o = t[OUT_W-1:0];
        end
        return o;
    endfunction

endpackage

// File: hw/rtl/aar_cordic_cell.sv
// one rotation step of the pipelined cordic chain
module aar_cordic_cell #(
    parameter int XW  = 19,
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  aar_pkg::t_cell_ctl                i_ctl,
    input  logic signed [XW-1:0]              i_x,
    input  logic signed [XW-1:0]              i_y,
    input  logic signed [aar_pkg::Z_W-1:0]    i_z,
    input  aar_pkg::t_axis                    i_axis,
    output aar_pkg::t_cell_ctl                o_ctl,
    output logic signed [XW-1:0]              o_x,
    output logic signed [XW-1:0]              o_y,
    output logic signed [aar_pkg::Z_W-1:0]    o_z,
    output aar_pkg::t_axis                    o_axis
);

    localparam logic signed [aar_pkg::Z_W-1:0] ATAN = aar_pkg::atan_phase(IDX);

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [aar_pkg::Z_W-1:0] n_z;

    aar_pkg::t_cell_ctl r_ctl;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [aar_pkg::Z_W-1:0] r_z;
    aar_pkg::t_axis r_axis;

    assign w_dx = i_y >>> IDX;
    assign w_dy = i_x >>> IDX;

    always_comb begin
        // non-negative residual rotates counterclockwise
        if (i_z >= 0) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_axis <= i_axis;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_axis = r_axis;

endmodule

// File: hw/rtl/aar_matrix.sv
// rodrigues matrix entries: products, scaling, rounding and saturation
module aar_matrix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [aar_pkg::C_W-1:0]       i_c,
    input  logic signed [aar_pkg::C_W-1:0]       i_s,
    input  logic signed [aar_pkg::OMC_W-1:0]     i_omc,
    input  aar_pkg::t_axis                       i_axis,
    output logic                                 o_valid,
    output logic signed [aar_pkg::OUT_W-1:0]     o_r [aar_pkg::NUM_OUT]
);

    localparam int PP_W  = aar_pkg::PP_W;
    localparam int NS_W  = aar_pkg::NS_W;
    localparam int Q_W   = aar_pkg::Q_W;
    localparam int SUM_W = aar_pkg::SUM_W;
    localparam int C_W   = aar_pkg::C_W;

    // stage a: axis products and axis times sine
    logic r_a_valid;
    logic signed [PP_W-1:0] r_a_xx, r_a_yy, r_a_zz, r_a_xy, r_a_xz, r_a_yz;
    logic signed [NS_W-1:0] r_a_sx, r_a_sy, r_a_sz;
    logic signed [C_W-1:0] r_a_c;
    logic signed [aar_pkg::OMC_W-1:0] r_a_omc;

    // stage b: axis products times one minus cosine
    logic r_b_valid;
    logic signed [Q_W-1:0] r_b_xx, r_b_yy, r_b_zz, r_b_xy, r_b_xz, r_b_yz;
    logic signed [NS_W-1:0] r_b_sx, r_b_sy, r_b_sz;
    logic signed [C_W-1:0] r_b_c;

    // output stage
    logic r_o_valid;
    logic signed [aar_pkg::OUT_W-1:0] r_o [aar_pkg::NUM_OUT];

    logic signed [SUM_W-1:0] w_c48;
    logic signed [SUM_W-1:0] w_sx, w_sy, w_sz;
    logic signed [SUM_W-1:0] w_xx, w_yy, w_zz, w_xy, w_xz, w_yz;
    logic signed [SUM_W-1:0] n_sum [aar_pkg::NUM_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xx  <= i_axis.x * i_axis.x;
            r_a_yy  <= i_axis.y * i_axis.y;
            r_a_zz  <= i_axis.z * i_axis.z;
            r_a_xy  <= i_axis.x * i_axis.y;
            r_a_xz  <= i_axis.x * i_axis.z;
            r_a_yz  <= i_axis.y * i_axis.z;
            r_a_sx  <= i_axis.x * i_s;
            r_a_sy  <= i_axis.y * i_s;
            r_a_sz  <= i_axis.z * i_s;
            r_a_c   <= i_c;
            r_a_omc <= i_omc;

            r_b_xx <= r_a_xx * r_a_omc;
            r_b_yy <= r_a_yy * r_a_omc;
            r_b_zz <= r_a_zz * r_a_omc;
            r_b_xy <= r_a_xy * r_a_omc;
            r_b_xz <= r_a_xz * r_a_omc;
            r_b_yz <= r_a_yz * r_a_omc;
            r_b_sx <= r_a_sx;
            r_b_sy <= r_a_sy;
            r_b_sz <= r_a_sz;
            r_b_c  <= r_a_c;

            for (int k = 0; k < aar_pkg::NUM_OUT; k++) begin
                r_o[k] <= aar_pkg::sat_out(n_sum[k]);
            end
        end
    end

    // align everything to q.48
    assign w_c48 = {{(SUM_W-C_W-32){r_b_c[C_W-1]}}, r_b_c, 32'd0};
    assign w_sx  = {{(SUM_W-NS_W-16){r_b_sx[NS_W-1]}}, r_b_sx, 16'd0};
    assign w_sy  = {{(SUM_W-NS_W-16){r_b_sy[NS_W-1]}}, r_b_sy, 16'd0};
    assign w_sz  = {{(SUM_W-NS_W-16){r_b_sz[NS_W-1]}}, r_b_sz, 16'd0};
    assign w_xx  = {{(SUM_W-Q_W){r_b_xx[Q_W-1]}}, r_b_xx};
    assign w_yy  = {{(SUM_W-Q_W){r_b_yy[Q_W-1]}}, r_b_yy};
    assign w_zz  = {{(SUM_W-Q_W){r_b_zz[Q_W-1]}}, r_b_zz};
    assign w_xy  = {{(SUM_W-Q_W){r_b_xy[Q_W-1]}}, r_b_xy};
    assign w_xz  = {{(SUM_W-Q_W){r_b_xz[Q_W-1]}}, r_b_xz};
    assign w_yz  = {{(SUM_W-Q_W){r_b_yz[Q_W-1]}}, r_b_yz};

    always_comb begin
        n_sum[0] = w_c48 + w_xx;
        n_sum[1] = w_xy - w_sz;
        n_sum[2] = w_xz + w_sy;
        n_sum[3] = w_xy + w_sz;
        n_sum[4] = w_c48 + w_yy;
        n_sum[5] = w_yz - w_sx;
        n_sum[6] = w_xz - w_sy;
        n_sum[7] = w_yz + w_sx;
        n_sum[8] = w_c48 + w_zz;
    end

    assign o_valid = r_o_valid;
    assign o_r     = r_o;

endmodule

// File: hw/rtl/axis_angle_rotation_matrix.sv
// top level: angle to phase, cordic chain, cosine/sine scaling, matrix entries
//
// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_angle, i_axis_x, i_axis_y, i_axis_z
// result    out        o_valid / i_ready   o_r00 .. o_r22
//
// one request per cycle while the result is not stalled; the pipeline is the
// chain of cordic cells (one rotation per cell) plus two phase stages
// (product, quadrant fold), one scaling stage, two multiplier stages and
// the rounding and saturation stage.
// synchronous active-low reset clears every valid flag; data registers are not reset.
// a stalled result holds the whole pipeline, so o_ready = !o_valid || i_ready.
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STEPS = 18,
    parameter int FRAC_BITS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [aar_pkg::ANGLE_W-1:0] i_angle,
    input  logic signed [aar_pkg::AXIS_W-1:0]  i_axis_x,
    input  logic signed [aar_pkg::AXIS_W-1:0]  i_axis_y,
    input  logic signed [aar_pkg::AXIS_W-1:0]  i_axis_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r00,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r01,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r02,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r10,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r11,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r12,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r20,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r21,
    output logic signed [aar_pkg::OUT_W-1:0]   o_r22
);

    localparam int XW   = FRAC_BITS + 3;
    localparam int Z_W  = aar_pkg::Z_W;
    localparam int C_W  = aar_pkg::C_W;
    localparam int PR_W = aar_pkg::ANGLE_W + 31;
    localparam logic [63:0] X0_FULL =
        (aar_pkg::GAIN_INV_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [XW-1:0] X0 = X0_FULL[XW-1:0];
    localparam logic signed [Z_W-1:0] QUARTER = 32'sd1073741824;

    logic w_en;
    logic w_out_valid;

    // phase product stage
    logic r_s0_valid;
    logic signed [PR_W-1:0] r_s0_prod;
    aar_pkg::t_axis r_s0_axis;

    // quadrant fold stage
    logic [50:0] w_u;
    logic [Z_W-1:0] w_ph;
    logic signed [Z_W-1:0] w_z;
    logic signed [Z_W-1:0] n_s1_z;
    logic n_s1_flip;
    aar_pkg::t_cell_ctl r_s1_ctl;
    logic signed [Z_W-1:0] r_s1_z;
    aar_pkg::t_axis r_s1_axis;

    // cordic chain links
    aar_pkg::t_cell_ctl w_ctl [CORDIC_STEPS+1];
    logic signed [XW-1:0] w_x [CORDIC_STEPS+1];
    logic signed [XW-1:0] w_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] w_zc [CORDIC_STEPS+1];
    aar_pkg::t_axis w_axis [CORDIC_STEPS+1];

    // scaling stage
    logic signed [XW-1:0] w_xf;
    logic signed [XW-1:0] w_yf;
    logic signed [C_W-1:0] n_c;
    logic signed [C_W-1:0] n_s;
    logic r_tr_valid;
    logic signed [C_W-1:0] r_tr_c;
    logic signed [C_W-1:0] r_tr_s;
    logic signed [aar_pkg::OMC_W-1:0] r_tr_omc;
    aar_pkg::t_axis r_tr_axis;

    logic signed [aar_pkg::OUT_W-1:0] w_r [aar_pkg::NUM_OUT];

    assign w_en    = !w_out_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_ctl   <= '0;
            r_tr_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid     <= i_valid;
            r_s1_ctl.valid <= r_s0_valid;
            r_s1_ctl.flip  <= n_s1_flip;
            r_tr_valid     <= w_ctl[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_prod   <= i_angle * $signed({1'b0, aar_pkg::PHASE_PER_RAD});
            r_s0_axis.x <= i_axis_x;
            r_s0_axis.y <= i_axis_y;
            r_s0_axis.z <= i_axis_z;
            r_s1_z      <= n_s1_z;
            r_s1_axis   <= r_s0_axis;
            r_tr_c      <= n_c;
            r_tr_s      <= n_s;
            r_tr_omc    <= aar_pkg::ONE_Q16 - {n_c[C_W-1], n_c};
            r_tr_axis   <= w_axis[CORDIC_STEPS];
        end
    end

    // radians to a 32-bit phase with round half up; only the low bits survive the wrap
    assign w_u  = r_s0_prod[50:0] + (51'd1 << 18);
    assign w_ph = w_u[50:19];
    assign w_z  = w_ph;

    always_comb begin
        // beyond a quarter turn: move by a half turn (top bit flip) and negate later
        if (w_z > QUARTER || w_z < -QUARTER) begin
            n_s1_z    = {~w_ph[Z_W-1], w_ph[Z_W-2:0]};
            n_s1_flip = 1'b1;
        end else begin
            n_s1_z    = w_z;
            n_s1_flip = 1'b0;
        end
    end

    assign w_ctl[0]  = r_s1_ctl;
    assign w_x[0]    = X0;
    assign w_y[0]    = '0;
    assign w_zc[0]   = r_s1_z;
    assign w_axis[0] = r_s1_axis;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        aar_cordic_cell #(
            .XW  (XW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_zc[g]),
            .i_axis  (w_axis[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_zc[g+1]),
            .o_axis  (w_axis[g+1])
        );
    end

    assign w_xf = w_ctl[CORDIC_STEPS].flip ? -w_x[CORDIC_STEPS] : w_x[CORDIC_STEPS];
    assign w_yf = w_ctl[CORDIC_STEPS].flip ? -w_y[CORDIC_STEPS] : w_y[CORDIC_STEPS];

    // rescale to 16 fraction bits, halves up where fraction bits are dropped
    if (FRAC_BITS > 16) begin : g_round
        localparam int SH = FRAC_BITS - 16;
        localparam logic signed [XW-1:0] HALF = XW'(64'd1 << (SH - 1));
        logic signed [XW-1:0] w_cr;
        logic signed [XW-1:0] w_sr;
        assign w_cr = w_xf + HALF;
        assign w_sr = w_yf + HALF;
        assign n_c  = C_W'(w_cr >>> SH);
        assign n_s  = C_W'(w_sr >>> SH);
    end else if (FRAC_BITS == 16) begin : g_same
        assign n_c = C_W'(w_xf);
        assign n_s = C_W'(w_yf);
    end else begin : g_widen
        assign n_c = C_W'({w_xf, {(16 - FRAC_BITS){1'b0}}});
        assign n_s = C_W'({w_yf, {(16 - FRAC_BITS){1'b0}}});
    end

    aar_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_tr_valid),
        .i_c     (r_tr_c),
        .i_s     (r_tr_s),
        .i_omc   (r_tr_omc),
        .i_axis  (r_tr_axis),
        .o_valid (w_out_valid),
        .o_r     (w_r)
    );

    assign o_valid = w_out_valid;
    assign o_r00   = w_r[0];
    assign o_r01   = w_r[1];
    assign o_r02   = w_r[2];
    assign o_r10   = w_r[3];
    assign o_r11   = w_r[4];
    assign o_r12   = w_r[5];
    assign o_r20   = w_r[6];
    assign o_r21   = w_r[7];
    assign o_r22   = w_r[8];

`ifndef SYNTH
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_ctl.valid |-> (r_s1_z <= QUARTER && r_s1_z >= -QUARTER))
        else $error("folded phase outside a quarter turn");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tr_valid |-> (r_tr_c <= 19'sd66000 && r_tr_c >= -19'sd66000
                        && r_tr_s <= 19'sd66000 && r_tr_s >= -19'sd66000))
        else $error("cosine or sine beyond unit magnitude");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s1_ctl) && $stable(r_tr_valid)))
        else $error("pipeline advanced while the result was stalled");
`endif

endmodule
